/* src/rpe_pkg.sv */
package rpe_pkg;

    localparam int TABLE_DEPTH_DEF  = 16384;
    localparam int MAX_HALF_DIM_DEF = 128;
    localparam logic [7:0] HALF_DIM_RESET = 8'd64;

    // op codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_ROTATE = 1'b1;

    typedef struct packed {
        logic               op;
        logic [11:0]        position;
        logic [6:0]         pair_index;
        logic signed [15:0] x_even;
        logic signed [15:0] x_odd;
        logic signed [15:0] sine_in;
        logic signed [15:0] cosine_in;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] y_even;
        logic signed [15:0] y_odd;
        logic               range_error;
    } t_out_item;

    // load enables of the two rotate stages
    typedef struct packed {
        logic load_mul;
        logic load_out;
    } t_rot_en;

    // round half up at bit 15, shift by 15, saturate to 16 bits
    function automatic logic signed [15:0] round_sat(input logic signed [33:0] sum);
        logic signed [33:0] biased;
        logic signed [18:0] q;
        biased = sum + 34'sd16384;
        q = biased[33:15];
        if (q > 19'sd32767) begin
            return 16'sh7fff;
        end else if (q < -19'sd32768) begin
            return 16'sh8000;
        end else begin
            return q[15:0];
        end
    endfunction

endpackage

/* src/rpe_rotate.sv */
module rpe_rotate (
    input  logic                i_clk,
    input  rpe_pkg::t_rot_en    i_en,
    input  logic signed [15:0]  i_x_even,
    input  logic signed [15:0]  i_x_odd,
    input  logic signed [15:0]  i_sin,
    input  logic signed [15:0]  i_cos,
    input  logic                i_zero,
    input  logic                i_range_error,
    output rpe_pkg::t_out_item  o_item
);

    logic signed [31:0] r_p_ec, r_p_os, r_p_es, r_p_oc;
    logic               r_zero, r_range_error;
    rpe_pkg::t_out_item r_item;
    rpe_pkg::t_out_item n_item;

    // four independent products
    always_ff @(posedge i_clk) begin
        if (i_en.load_mul) begin
            r_p_ec        <= i_x_even * i_cos;
            r_p_os        <= i_x_odd * i_sin;
            r_p_es        <= i_x_even * i_sin;
            r_p_oc        <= i_x_odd * i_cos;
            r_zero        <= i_zero;
            r_range_error <= i_range_error;
        end
    end

    always_comb begin
        n_item.range_error = r_range_error;
        if (r_zero) begin
            n_item.y_even = '0;
            n_item.y_odd  = '0;
        end else begin
            n_item.y_even = rpe_pkg::round_sat(34'(r_p_ec) - 34'(r_p_os));
            n_item.y_odd  = rpe_pkg::round_sat(34'(r_p_es) + 34'(r_p_oc));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_out) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

/* src/rotary_position_embedding_unit.sv */
// rotary position embedding on interleaved element pairs
// input channel: i_in_valid / o_in_ready carry one t_in_item per transfer.
//   op write stores {cosine_in, sine_in} at position*half_dim + pair_index,
//   op rotate reads that entry and turns (x_even, x_odd) by the stored angle
// output channel: o_out_valid / i_out_ready carry one t_out_item per transfer,
//   one result for every item, in order; writes return zeros
// an address at or beyond TABLE_DEPTH sets range_error, writes nothing and
//   returns zeros; a half_dim above MAX_HALF_DIM is used as MAX_HALF_DIM
// half_dim is written through i_cfg_we / i_cfg_data; the user writes it
//   only while the block is idle, which the block itself does not enforce
// stages: address register, table read, multiply, then round and saturate
//   into the output register; the address is formed in the transfer's cycle
// throughput: one item per cycle while the receiver takes results, set by
//   the single table port that serves one address each cycle
// reset clears the pipeline valids and sets half_dim to 64; the table is not
//   cleared and an entry must be written before it is read
// a stalled receiver holds the output; the stages behind it keep filling
//   and o_in_ready drops only once all four stages hold an item
module rotary_position_embedding_unit #(
    parameter int TABLE_DEPTH  = rpe_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_HALF_DIM = rpe_pkg::MAX_HALF_DIM_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rpe_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rpe_pkg::t_out_item o_out_item
);

    localparam int SW = $clog2(MAX_HALF_DIM + 1);       // stride width
    localparam int AW = 12 + SW + 1;                    // full address width
    localparam int MW = $clog2(TABLE_DEPTH);            // table index width

    // configuration
    logic [7:0] r_half_dim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_dim <= rpe_pkg::HALF_DIM_RESET;
        end else if (i_cfg_we) begin
            r_half_dim <= i_cfg_data;
        end
    end

    // stage enables: a stage loads when it is empty or its successor loads
    logic en1, en2, en3, en_o;
    logic r_v1, r_v2, r_v3, r_vo;

    assign en_o = !r_vo || i_out_ready;
    assign en3  = !r_v3 || en_o;
    assign en2  = !r_v2 || en3;
    assign en1  = !r_v1 || en2;

    assign o_in_ready  = en1;
    assign o_out_valid = r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en1)  r_v1 <= i_in_valid;
            if (en2)  r_v2 <= r_v1;
            if (en3)  r_v3 <= r_v2;
            if (en_o) r_vo <= r_v3;
        end
    end

    // address: clamp the stride, then position*stride + pair
    logic [SW-1:0] w_stride;
    logic [AW-1:0] w_addr_full;
    logic          w_in_range;

    always_comb begin
        if (32'(r_half_dim) > MAX_HALF_DIM) begin
            w_stride = SW'(MAX_HALF_DIM);
        end else begin
            w_stride = SW'(r_half_dim);
        end
    end

    assign w_addr_full = AW'(i_in_item.position) * AW'(w_stride)
                       + AW'(i_in_item.pair_index);
    assign w_in_range  = 32'(w_addr_full) < TABLE_DEPTH;

    // stage 1: address registered
    logic               r_op1, r_inr1;
    logic [MW-1:0]      r_addr1;
    logic signed [15:0] r_xe1, r_xo1, r_sin1, r_cos1;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_op1   <= i_in_item.op;
            r_inr1  <= w_in_range;
            r_addr1 <= MW'(w_addr_full);
            r_xe1   <= i_in_item.x_even;
            r_xo1   <= i_in_item.x_odd;
            r_sin1  <= i_in_item.sine_in;
            r_cos1  <= i_in_item.cosine_in;
        end
    end

    // angle table: cosine high, sine low; one access per item in order,
    // so a read always sees every earlier write
    logic [31:0] mem_angle [TABLE_DEPTH];
    logic [31:0] r_rdata;
    logic        w_mem_go, w_mem_we;

    assign w_mem_go = en2 && r_v1;
    assign w_mem_we = w_mem_go && (r_op1 == rpe_pkg::OP_WRITE) && r_inr1;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_angle[r_addr1] <= {r_cos1, r_sin1};
        end
        if (w_mem_go) begin
            r_rdata <= mem_angle[r_addr1];
        end
    end

    // stage 2: table data arrives
    logic               r_zero2, r_rerr2;
    logic signed [15:0] r_xe2, r_xo2;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_zero2 <= !((r_op1 == rpe_pkg::OP_ROTATE) && r_inr1);
            r_rerr2 <= !r_inr1;
            r_xe2   <= r_xe1;
            r_xo2   <= r_xo1;
        end
    end

    // stages 3 and output: multiply, then round and saturate
    rpe_pkg::t_rot_en w_rot_en;

    assign w_rot_en.load_mul = en3;
    assign w_rot_en.load_out = en_o;

    rpe_rotate u_rotate (
        .i_clk         (i_clk),
        .i_en          (w_rot_en),
        .i_x_even      (r_xe2),
        .i_x_odd       (r_xo2),
        .i_sin         (r_rdata[15:0]),
        .i_cos         (r_rdata[31:16]),
        .i_zero        (r_zero2),
        .i_range_error (r_rerr2),
        .o_item        (o_out_item)
    );

`ifndef SYNTHESIS
    // an in-range write moves on as a zero result
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_go && (r_op1 == rpe_pkg::OP_WRITE)) |=> (r_v2 && r_zero2))
        else $error("write item not marked for zero result");

    // input stalls only when every stage holds an item
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v1 && r_v2 && r_v3 && r_vo && !i_out_ready))
        else $error("input stalled with a free stage");

    // an out-of-range result carries zeros
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.range_error)
            |-> (o_out_item.y_even == 16'sd0 && o_out_item.y_odd == 16'sd0))
        else $error("range error with nonzero result");
`endif

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    // four pipeline stages plus margin
    localparam int PIPE_SLACK  = 8;
    // long receiver hold-off, enough to fill every stage and stall the input
    localparam int LONG_HOLD   = 48;

    typedef struct {
        logic [7:0]         half_dim;
        rpe_pkg::t_in_item  item;
        bit                 typed;
        rpe_pkg::t_out_item result;
    } t_plan_row;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [7:0]         cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    rpe_pkg::t_in_item  in_item = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    rpe_pkg::t_out_item out_item;

    // mirror of the angle store and the stride register
    logic [31:0] angle_mem [rpe_pkg::TABLE_DEPTH_DEF];
    bit          entry_written [rpe_pkg::TABLE_DEPTH_DEF];
    logic [7:0]  model_half_dim = rpe_pkg::HALF_DIM_RESET;

    // results owed by the block, oldest first
    rpe_pkg::t_out_item owed_results [$];
    // in-range writes under the current stride, source of well-formed rotates
    rpe_pkg::t_in_item  recent_writes [$];
    t_plan_row          plan [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;

    rotary_position_embedding_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // stride actually used: values above the maximum are clamped
    function automatic int unsigned row_stride();
        return (model_half_dim > rpe_pkg::MAX_HALF_DIM_DEF) ?
               rpe_pkg::MAX_HALF_DIM_DEF : model_half_dim;
    endfunction

    function automatic int unsigned entry_addr(input rpe_pkg::t_in_item it);
        return it.position * row_stride() + it.pair_index;
    endfunction

    // round half up at bit 15, drop 15 bits, clip to a signed 16-bit element
    function automatic logic signed [15:0] round_to_element(input longint acc);
        longint q;
        q = (acc + 64'sd16384) >>> 15;
        if (q > 32767) return 16'sh7fff;
        if (q < -32768) return 16'sh8000;
        return q[15:0];
    endfunction

    // expected result of one item; a write also updates the mirrored store
    function automatic rpe_pkg::t_out_item rotate_pair(input rpe_pkg::t_in_item it);
        rpe_pkg::t_out_item r;
        int unsigned        addr;
        logic signed [15:0] sn;
        logic signed [15:0] cs;
        r = '0;
        addr = entry_addr(it);
        if (addr >= rpe_pkg::TABLE_DEPTH_DEF) begin
            r.range_error = 1'b1;
        end else if (it.op == rpe_pkg::OP_WRITE) begin
            angle_mem[addr] = {it.cosine_in, it.sine_in};
            entry_written[addr] = 1'b1;
        end else begin
            cs = angle_mem[addr][31:16];
            sn = angle_mem[addr][15:0];
            r.y_even = round_to_element(longint'(it.x_even) * cs - longint'(it.x_odd) * sn);
            r.y_odd  = round_to_element(longint'(it.x_even) * sn + longint'(it.x_odd) * cs);
        end
        return r;
    endfunction

    // random 16-bit word, leaning on the corners now and then
    function automatic logic [15:0] rand_word();
        case ($urandom_range(7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly writes followed by rotates of what was written, plus some noise
    function automatic rpe_pkg::t_in_item draw_item();
        rpe_pkg::t_in_item it;
        rpe_pkg::t_in_item prev;
        int unsigned       pick;
        int unsigned       s;
        int unsigned       top_pos;
        int unsigned       room;
        pick = $urandom_range(99);
        s = row_stride();
        it.op = rpe_pkg::OP_WRITE;
        it.position = 12'($urandom_range(4095));
        it.pair_index = 7'($urandom_range(127));
        it.x_even = rand_word();
        it.x_odd = rand_word();
        it.sine_in = rand_word();
        it.cosine_in = rand_word();
        if (pick < 35 || (pick < 80 && recent_writes.size() == 0)) begin
            // write somewhere inside the store; a zero stride is always inside
            if (s != 0) begin
                top_pos = (rpe_pkg::TABLE_DEPTH_DEF - 1) / s;
                if (top_pos > 4095) top_pos = 4095;
                it.position = 12'($urandom_range(top_pos));
                room = rpe_pkg::TABLE_DEPTH_DEF - 1 - it.position * s;
                it.pair_index = 7'($urandom_range(room > 127 ? 127 : room));
            end
        end else if (pick < 80) begin
            // rotate a recent entry, often the one just written
            if ($urandom_range(1)) begin
                prev = recent_writes[$];
            end else begin
                prev = recent_writes[$urandom_range(recent_writes.size() - 1)];
            end
            it.op = rpe_pkg::OP_ROTATE;
            it.position = prev.position;
            it.pair_index = prev.pair_index;
        end else begin
            // noise, but never a read of an entry that holds nothing yet
            it.op = 1'($urandom_range(1));
            if (it.op == rpe_pkg::OP_ROTATE && entry_addr(it) < rpe_pkg::TABLE_DEPTH_DEF &&
                !entry_written[entry_addr(it)]) begin
                it.op = rpe_pkg::OP_WRITE;
            end
        end
        if (it.op == rpe_pkg::OP_WRITE && entry_addr(it) < rpe_pkg::TABLE_DEPTH_DEF) begin
            recent_writes.push_back(it);
            if (recent_writes.size() > 32) void'(recent_writes.pop_front());
        end
        return it;
    endfunction

    task automatic add_row(input int hd, input logic op, input int pos, input int pair,
                           input logic [15:0] xe, input logic [15:0] xo,
                           input logic [15:0] sn, input logic [15:0] cs,
                           input bit typed, input logic [15:0] ye,
                           input logic [15:0] yo, input bit err);
        t_plan_row row;
        row.half_dim = 8'(hd);
        row.item.op = op;
        row.item.position = 12'(pos);
        row.item.pair_index = 7'(pair);
        row.item.x_even = xe;
        row.item.x_odd = xo;
        row.item.sine_in = sn;
        row.item.cosine_in = cs;
        row.typed = typed;
        row.result.y_even = ye;
        row.result.y_odd = yo;
        row.result.range_error = err;
        plan.push_back(row);
    endtask

    // offer one item, with random idle cycles first; valid holds until the transfer
    task automatic push_item(input rpe_pkg::t_in_item it, input rpe_pkg::t_out_item want);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        owed_results.push_back(want);
    endtask

    // stop offering and wait for every owed result, then let the pipe empty
    task automatic settle_pipeline();
        in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    task automatic set_half_dim(input logic [7:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_half_dim = v;
        recent_writes.delete();
    endtask

    // output side: check each result transfer, then pick next cycle's ready
    always @(posedge clk) begin : result_side
        rpe_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (owed_results.size() == 0) begin
                $error("result with nothing owed: y_even %0d y_odd %0d range_error %0b",
                       out_item.y_even, out_item.y_odd, out_item.range_error);
                errors++;
            end else begin
                want = owed_results.pop_front();
                if (out_item.y_even !== want.y_even) begin
                    $error("y_even: expected %0d, got %0d", want.y_even, out_item.y_even);
                    errors++;
                end
                if (out_item.y_odd !== want.y_odd) begin
                    $error("y_odd: expected %0d, got %0d", want.y_odd, out_item.y_odd);
                    errors++;
                end
                if (out_item.range_error !== want.range_error) begin
                    $error("range_error: expected %0b, got %0b",
                           want.range_error, out_item.range_error);
                    errors++;
                end
            end
        end
        // a requested long hold-off wins over the random stalls
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned phase_hd   [8] = '{64, 1, 128, 255, 0, 37, 64, 100};
        int unsigned phase_send [8] = '{0, 75, 0, 13, 0, 75, 13, 0};
        int unsigned phase_recv [8] = '{0, 0, 75, 13, 0, 0, 13, 75};
        int unsigned phase_len  [8] = '{250, 230, 230, 230, 150, 230, 250, 280};
        int unsigned        p;
        int unsigned        k;
        rpe_pkg::t_in_item  it;
        rpe_pkg::t_out_item want;

        // directed rows: stride, op, position, pair, x_even, x_odd, sine, cosine,
        // then a typed result where it is obvious
        // cosine near one, then extreme elements through it
        add_row(64, rpe_pkg::OP_WRITE, 0, 0, 'h0000, 'h0000, 'h0000, 'h7fff, 1, 0, 0, 0);
        add_row(64, rpe_pkg::OP_ROTATE, 0, 0, 'h7fff, 'h8000, 'h0000, 'h0000, 0, 0, 0, 0);
        // cosine one half at row 1; read back through pair 64 of row 0
        add_row(64, rpe_pkg::OP_WRITE, 1, 0, 'h0000, 'h0000, 'h0000, 'h4000, 1, 0, 0, 0);
        add_row(64, rpe_pkg::OP_ROTATE, 0, 64, 'h0100, 'h0000, 'h0000, 'h0000,
                1, 'h0080, 0, 0);
        // exact half ties round up
        add_row(64, rpe_pkg::OP_ROTATE, 1, 0, 'h0001, 'hffff, 'h0000, 'h0000,
                1, 'h0001, 0, 0);
        // clipping to the positive and the negative limit
        add_row(64, rpe_pkg::OP_WRITE, 2, 3, 'h0000, 'h0000, 'h8000, 'h8000, 1, 0, 0, 0);
        add_row(64, rpe_pkg::OP_ROTATE, 2, 3, 'h8000, 'h7fff, 'h0000, 'h0000, 0, 0, 0, 0);
        add_row(64, rpe_pkg::OP_WRITE, 2, 4, 'h0000, 'h0000, 'h8000, 'h7fff, 1, 0, 0, 0);
        add_row(64, rpe_pkg::OP_ROTATE, 2, 4, 'h8000, 'h8000, 'h0000, 'h0000, 0, 0, 0, 0);
        // last entry of the store
        add_row(64, rpe_pkg::OP_WRITE, 255, 63, 'h0000, 'h0000, 'h1234, 'hedcb, 1, 0, 0, 0);
        add_row(64, rpe_pkg::OP_ROTATE, 255, 63, 'hffff, 'h0001, 'h0000, 'h0000, 0, 0, 0, 0);
        // first address past the end, and the farthest one
        add_row(64, rpe_pkg::OP_WRITE, 256, 0, 'hffff, 'hffff, 'hffff, 'hffff, 1, 0, 0, 1);
        add_row(64, rpe_pkg::OP_ROTATE, 4095, 127, 'h7fff, 'h7fff, 'h0000, 'h0000,
                1, 0, 0, 1);
        // pair beyond half_dim lands in the next row
        add_row(64, rpe_pkg::OP_WRITE, 1, 63, 'h0000, 'h0000, 'h7fff, 'h0000, 1, 0, 0, 0);
        add_row(64, rpe_pkg::OP_ROTATE, 0, 127, 'h0100, 'h0200, 'h0000, 'h0000, 0, 0, 0, 0);
        // zero stride: the address is the pair alone
        add_row(0, rpe_pkg::OP_WRITE, 100, 5, 'h0000, 'h0000, 'h5a5a, 'ha5a5, 1, 0, 0, 0);
        add_row(0, rpe_pkg::OP_ROTATE, 4095, 5, 'h1357, 'hfedc, 'h0000, 'h0000, 0, 0, 0, 0);
        // oversized stride is clamped, so row 127 pair 127 is still inside
        add_row(255, rpe_pkg::OP_WRITE, 127, 127, 'h0000, 'h0000, 'h0001, 'hfffe,
                1, 0, 0, 0);
        add_row(255, rpe_pkg::OP_ROTATE, 127, 127, 'hffff, 'h8000, 'h0000, 'h0000,
                0, 0, 0, 0);
        add_row(255, rpe_pkg::OP_WRITE, 128, 0, 'h0000, 'h0000, 'h1111, 'h2222, 1, 0, 0, 1);
        // unit stride, largest position and pair
        add_row(1, rpe_pkg::OP_WRITE, 4095, 127, 'h0000, 'h0000, 'hc000, 'h3fff, 1, 0, 0, 0);
        add_row(1, rpe_pkg::OP_ROTATE, 4095, 127, 'h7fff, 'h0100, 'h0000, 'h0000,
                0, 0, 0, 0);

        phase_hd[5] = $urandom_range(2, 127);
        phase_hd[7] = $urandom_range(1, 128);

        // hold the synchronous reset, then release it
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling; the stride changes only with the pipe empty
        foreach (plan[n]) begin
            if (plan[n].half_dim != model_half_dim) begin
                settle_pipeline();
                set_half_dim(plan[n].half_dim);
            end
            want = rotate_pair(plan[n].item);
            if (plan[n].typed) want = plan[n].result;
            push_item(plan[n].item, want);
        end

        // random phases, each with its own stride and idling mix
        for (p = 0; p < 8; p++) begin
            settle_pipeline();
            set_half_dim(8'(phase_hd[p]));
            send_idle_pct = phase_send[p];
            recv_stall_pct = phase_recv[p];
            // long hold-off while the sender keeps offering transfers
            if (p == 0 || p == 4) hold_requests++;
            for (k = 0; k < phase_len[p]; k++) begin
                // sender pause until every owed result is back
                if (k == phase_len[p] / 2) settle_pipeline();
                it = draw_item();
                want = rotate_pair(it);
                push_item(it, want);
            end
        end

        settle_pipeline();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
